>>> hdl/pfra_pkg.sv
`timescale 1ns / 1ps

package pfra_pkg;

  // pool geometry
  localparam int NUM_PAGES  = 1024;
  localparam int PAGE_SHIFT = 12;
  localparam int COUNT_W    = 16;
  localparam int IDX_W      = $clog2(NUM_PAGES);
  localparam int FCNT_W     = $clog2(NUM_PAGES + 1);
  localparam int ADDR_W     = 32;
  localparam int PFN_W      = ADDR_W - PAGE_SHIFT;

  // operation codes
  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_SHARE   = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_QUERY   = 3'd3;
  localparam logic [2:0] OP_COW     = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FREE   = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_ZERO      = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] page_addr;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] result_addr;
    logic [15:0]       share_count;
    logic              copy_needed;
    logic              page_freed;
  } rsp_t;

  // classified request held in the queue
  typedef struct packed {
    logic [2:0]       op;
    logic             in_pool;
    logic [IDX_W-1:0] idx;
    logic [PFN_W-1:0] pfn;
  } entry_t;

  // physical address of a pooled page
  function automatic logic [ADDR_W-1:0] page_address(input logic [ADDR_W-1:0] base,
                                                     input logic [IDX_W-1:0] idx);
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] off;
    b   = {base[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    off = ADDR_W'(idx) << PAGE_SHIFT;
    return b + off;
  endfunction

endpackage

>>> hdl/pfra_ram.sv
`timescale 1ns / 1ps

module pfra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/pfra_queue.sv
`timescale 1ns / 1ps

module pfra_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pfra_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output pfra_pkg::entry_t head
);

  pfra_pkg::entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign nonempty = (fill != 2'd0);
  assign head     = slots[rd_ptr];

  // two-entry ring between front and back
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> hdl/pfra_front.sv
`timescale 1ns / 1ps

module pfra_front (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      pool_base,
  input  logic             busy,
  input  logic             req_valid,
  output logic             req_stall,
  input  pfra_pkg::req_t   req,
  input  logic             pop,
  output logic             q_nonempty,
  output pfra_pkg::entry_t q_head
);

  logic [pfra_pkg::PFN_W-1:0] req_pfn;
  logic [pfra_pkg::PFN_W-1:0] base_pfn;
  logic [pfra_pkg::PFN_W-1:0] diff;
  logic                       q_full;
  logic                       push;
  pfra_pkg::entry_t           entry;

  // page number relative to the pool base
  assign req_pfn  = req.page_addr[pfra_pkg::ADDR_W-1:pfra_pkg::PAGE_SHIFT];
  assign base_pfn = pool_base[pfra_pkg::ADDR_W-1:pfra_pkg::PAGE_SHIFT];
  assign diff     = req_pfn - base_pfn;

  // classify the request
  always_comb begin
    entry.op      = req.op;
    entry.in_pool = (req_pfn >= base_pfn) &&
                    (diff < pfra_pkg::PFN_W'(pfra_pkg::NUM_PAGES));
    entry.idx     = diff[pfra_pkg::IDX_W-1:0];
    entry.pfn     = req_pfn;
  end

  assign req_stall = busy || q_full;
  assign push      = req_valid && !req_stall;

  pfra_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (entry),
    .full      (q_full),
    .pop       (pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

endmodule

>>> hdl/pfra_back.sv
`timescale 1ns / 1ps

module pfra_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [31:0]      pool_base,
  output logic             busy,
  input  logic             q_nonempty,
  input  pfra_pkg::entry_t q_head,
  output logic             pop,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output pfra_pkg::rsp_t   rsp
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_COW
  } state_t;

  localparam logic [pfra_pkg::COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [pfra_pkg::COUNT_W-1:0] COUNT_ONE = pfra_pkg::COUNT_W'(1);
  localparam logic [pfra_pkg::IDX_W-1:0]   LAST_IDX  =
    pfra_pkg::IDX_W'(pfra_pkg::NUM_PAGES - 1);
  localparam logic [pfra_pkg::FCNT_W-1:0]  FULL_CNT  = pfra_pkg::FCNT_W'(pfra_pkg::NUM_PAGES);

  state_t                      state, state_next;
  logic [pfra_pkg::IDX_W-1:0]  clr, clr_next;
  logic [pfra_pkg::IDX_W-1:0]  head, head_next;
  logic [pfra_pkg::IDX_W-1:0]  tail, tail_next;
  logic [pfra_pkg::FCNT_W-1:0] free_cnt, free_cnt_next;
  pfra_pkg::entry_t            cur, cur_next;
  logic                        rsp_valid_next;
  pfra_pkg::rsp_t              rsp_next;

  logic                        cnt_we;
  logic [pfra_pkg::IDX_W-1:0]  cnt_wa;
  logic [pfra_pkg::COUNT_W-1:0] cnt_wd;
  logic [pfra_pkg::COUNT_W-1:0] cnt_rd;
  logic                        ring_we;
  logic [pfra_pkg::IDX_W-1:0]  ring_wa;
  logic [pfra_pkg::IDX_W-1:0]  ring_wd;
  logic [pfra_pkg::IDX_W-1:0]  ring_rd;
  logic [pfra_pkg::COUNT_W-1:0] cnt_dec;

  // share counts per page
  pfra_ram #(.WIDTH(pfra_pkg::COUNT_W), .DEPTH(pfra_pkg::NUM_PAGES)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_wa),
    .wdata (cnt_wd),
    .raddr (q_head.idx),
    .rdata (cnt_rd)
  );

  // free page ring
  pfra_ram #(.WIDTH(pfra_pkg::IDX_W), .DEPTH(pfra_pkg::NUM_PAGES)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_wa),
    .wdata (ring_wd),
    .raddr (head),
    .rdata (ring_rd)
  );

  assign busy    = (state == S_CLEAR);
  assign cnt_dec = cnt_rd - COUNT_ONE;

  // sequencer: read in the pop cycle, modify and write in the cycle after it
  always_comb begin
    state_next     = state;
    clr_next       = clr;
    head_next      = head;
    tail_next      = tail;
    free_cnt_next  = free_cnt;
    cur_next       = cur;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    pop            = 1'b0;
    cnt_we         = 1'b0;
    cnt_wa         = cur.idx;
    cnt_wd         = '0;
    ring_we        = 1'b0;
    ring_wa        = tail;
    ring_wd        = cur.idx;

    case (state)
      S_CLEAR: begin
        cnt_we   = 1'b1;
        cnt_wa   = clr;
        cnt_wd   = '0;
        ring_we  = 1'b1;
        ring_wa  = clr;
        ring_wd  = clr;
        clr_next = clr + 1'b1;
        if (clr == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (q_nonempty && (!rsp_valid || !rsp_stall)) begin
          pop        = 1'b1;
          cur_next   = q_head;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next     = S_IDLE;
        rsp_valid_next = 1'b1;
        rsp_next       = '0;
        rsp_next.status = pfra_pkg::ST_OK;
        case (cur.op)
          pfra_pkg::OP_ALLOC: begin
            if (free_cnt == '0) begin
              rsp_next.status = pfra_pkg::ST_NO_FREE;
            end else begin
              cnt_we                = 1'b1;
              cnt_wa                = ring_rd;
              cnt_wd                = COUNT_ONE;
              head_next             = (head == LAST_IDX) ? '0 : head + 1'b1;
              free_cnt_next         = free_cnt - 1'b1;
              rsp_next.result_addr  = pfra_pkg::page_address(pool_base, ring_rd);
              rsp_next.share_count  = 16'(COUNT_ONE);
            end
          end
          pfra_pkg::OP_SHARE: begin
            if (!cur.in_pool) begin
              rsp_next.status = pfra_pkg::ST_OUTSIDE;
            end else if (cnt_rd == '0) begin
              rsp_next.status = pfra_pkg::ST_ZERO;
            end else if (cnt_rd == COUNT_MAX) begin
              rsp_next.status      = pfra_pkg::ST_SATURATED;
              rsp_next.share_count = 16'(cnt_rd);
            end else begin
              cnt_we               = 1'b1;
              cnt_wd               = cnt_rd + COUNT_ONE;
              rsp_next.share_count = 16'(cnt_rd + COUNT_ONE);
            end
          end
          pfra_pkg::OP_RELEASE: begin
            if (!cur.in_pool) begin
              rsp_next.status = pfra_pkg::ST_OUTSIDE;
            end else if (cnt_rd == '0) begin
              rsp_next.status = pfra_pkg::ST_ZERO;
            end else begin
              cnt_we               = 1'b1;
              cnt_wd               = cnt_dec;
              rsp_next.share_count = 16'(cnt_dec);
              // back to the free list unless the ring is already full
              if (cnt_dec == '0 && free_cnt < FULL_CNT) begin
                ring_we             = 1'b1;
                tail_next           = (tail == LAST_IDX) ? '0 : tail + 1'b1;
                free_cnt_next       = free_cnt + 1'b1;
                rsp_next.page_freed = 1'b1;
              end
            end
          end
          pfra_pkg::OP_QUERY: begin
            if (!cur.in_pool) begin
              rsp_next.status = pfra_pkg::ST_OUTSIDE;
            end else begin
              rsp_next.share_count = 16'(cnt_rd);
            end
          end
          pfra_pkg::OP_COW: begin
            if (cur.in_pool && cnt_rd == '0) begin
              rsp_next.status = pfra_pkg::ST_ZERO;
            end else if (cur.in_pool && cnt_rd == COUNT_ONE) begin
              rsp_next.result_addr = {cur.pfn, {pfra_pkg::PAGE_SHIFT{1'b0}}};
              rsp_next.share_count = 16'(COUNT_ONE);
            end else if (free_cnt == '0) begin
              rsp_next.status = pfra_pkg::ST_NO_FREE;
            end else begin
              // drop the old page's count now, take the new page next cycle
              if (cur.in_pool) begin
                cnt_we = 1'b1;
                cnt_wd = cnt_dec;
              end
              rsp_valid_next = 1'b0;
              state_next     = S_COW;
            end
          end
          default: begin
            rsp_next.status = pfra_pkg::ST_OK;
          end
        endcase
      end

      S_COW: begin
        cnt_we               = 1'b1;
        cnt_wa               = ring_rd;
        cnt_wd               = COUNT_ONE;
        head_next            = (head == LAST_IDX) ? '0 : head + 1'b1;
        free_cnt_next        = free_cnt - 1'b1;
        rsp_next             = '0;
        rsp_next.status      = pfra_pkg::ST_OK;
        rsp_next.result_addr = pfra_pkg::page_address(pool_base, ring_rd);
        rsp_next.share_count = 16'(COUNT_ONE);
        rsp_next.copy_needed = 1'b1;
        rsp_valid_next       = 1'b1;
        state_next           = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    cur <= cur_next;
    rsp <= rsp_next;
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      head      <= '0;
      tail      <= '0;
      free_cnt  <= FULL_CNT;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      head      <= head_next;
      tail      <= tail_next;
      free_cnt  <= free_cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

>>> hdl/page_frame_refcount_allocator.sv
`timescale 1ns / 1ps

// Page frame allocator with per-page share counts over a pool of 1024 4 KiB pages.
// Request channel: req_valid / req_stall with req (op, page_addr); a request is
// taken at a clock edge with req_valid high and req_stall low. Response channel:
// rsp_valid / rsp_stall with rsp (status, result_addr, share_count, copy_needed,
// page_freed); exactly one response per request, in request order.
// cfg_we writes cfg_data into the pool base register; write it only while idle.
// A front stage classifies each request against the pool and places it in a
// two-entry queue; the back stage reads the count and free-ring memories in the
// cycle it takes a request and writes them back in the next one.
// The back stage takes a request only when it has finished the previous one; a
// copy-on-write that takes a new page needs an extra step (the count memory has
// one write port). After reset a clearing pass over all 1024 pages fills the
// free ring and zeroes all counts; req_stall stays high meanwhile. When the
// receiver holds rsp_stall the response stays put, the back stage stops and the
// queue fills, then req_stall rises.

module page_frame_refcount_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_data,
  input  logic           req_valid,
  output logic           req_stall,
  input  pfra_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pfra_pkg::rsp_t rsp
);

  logic [31:0]      pool_base;
  logic             busy;
  logic             q_nonempty;
  logic             pop;
  pfra_pkg::entry_t q_head;

  // pool base register
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_we) begin
      pool_base <= cfg_data;
    end
  end

  pfra_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pool_base  (pool_base),
    .busy       (busy),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .pop        (pop),
    .q_nonempty (q_nonempty),
    .q_head     (q_head)
  );

  pfra_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pool_base  (pool_base),
    .busy       (busy),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule
